// ----- hw/rtl/ile_pkg.sv -----
// shared constants, command and status codes, and cell control type
// for the indexed list engine; no dependencies
package ile_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the command and result transfers
  localparam int CMD_W     = 4;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 6;
  localparam int FIDX_W    = 6;
  localparam int CNT_OUT_W = 7;
  localparam int STATUS_W  = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 4'd0;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 4'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_REPLACE   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_READ      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 4'd7;
  localparam logic [CMD_W-1:0] CMD_FIND      = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DEL_VALUE = 4'd9;

  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

  // per-cell update operations
  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_OPEN  = 2'd1;
  localparam logic [1:0] CELL_CLOSE = 2'd2;
  localparam logic [1:0] CELL_WRITE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       cmp;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/ile_cmd_if.sv -----
// command channel: valid/ready handshake with cmd, value and position
// depends on ile_pkg
interface ile_cmd_if;
  import ile_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

// ----- hw/rtl/ile_res_if.sv -----
// result channel: valid/ready handshake with one result per command
// depends on ile_pkg
interface ile_res_if;
  import ile_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic [FIDX_W-1:0]         found_index;
  logic                      found;
  logic [CNT_OUT_W-1:0]      entry_count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output read_value, output found_index, output found,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input read_value, input found_index, input found,
                  input entry_count, input status, output ready);
endinterface

// ----- hw/rtl/indexed_list_engine_unit.sv -----
// top level of the indexed list engine: command sequencer, cell row, result register
// depends on ile_pkg, ile_cmd_if, ile_res_if, ile_chain
//
//   channel   direction  payload                                          role
//   command   in         cmd, value, position                             one list command
//   result    out        read_value, found_index, found, entry_count,     one result per command
//                        status
//
// a command runs through the transfer (every cell compares its word to the value),
// the select step (first match or position decode, status), and the update step in which
// every cell shifts, holds or loads at once
// reset clears the entry count, the sequencer and the result valid; cell words are not reset
// and are never read beyond the count
// the update step waits while the result register still holds an untaken result
// command ready is high only while no command is in flight and reset is low
module indexed_list_engine_unit #(
  parameter int DEPTH      = ile_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  ile_cmd_if.sink   command,
  ile_res_if.source result
);
  import ile_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int WW  = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
  localparam int LVL = $clog2(DEPTH);

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // captured command
  logic [CMD_W-1:0]      cmd_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] word_q;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // select step results
  logic [DEPTH-1:0]    tgt_q;
  logic [DEPTH-1:0]    ge_q;
  logic [1:0]          op_q;
  logic                rd_en_q;
  logic                found_q;
  logic [STATUS_W-1:0] status_q;

  // result register
  logic                      res_valid;
  logic signed [VALUE_W-1:0] res_read_value;
  logic [FIDX_W-1:0]         res_found_index;
  logic                      res_found;
  logic [CNT_OUT_W-1:0]      res_entry_count;
  logic [STATUS_W-1:0]       res_status;

  logic                  accept;
  logic                  exec_go;
  logic [DATA_WIDTH-1:0] in_word;
  logic [DEPTH-1:0]      match;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [VALUE_W-1:0]    rd_ext;
  cell_ctrl_t            ctrl;

  assign command.ready = (state == ST_IDLE) && !rst;
  assign accept        = command.valid && command.ready;
  assign exec_go       = (state == ST_EXEC) && (!res_valid || result.ready);

  // stored word is the low bits of the sign-extended value
  if (DATA_WIDTH <= VALUE_W) begin : g_in_narrow
    assign in_word = command.value[DATA_WIDTH-1:0];
  end else begin : g_in_wide
    assign in_word = {{(DATA_WIDTH-VALUE_W){command.value[VALUE_W-1]}}, command.value};
  end

  // read word is sign-extended from its own width, then cut to the field
  if (DATA_WIDTH >= VALUE_W) begin : g_rd_wide
    assign rd_ext = rd_word[VALUE_W-1:0];
  end else begin : g_rd_narrow
    assign rd_ext = {{(VALUE_W-DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
  end

  // cells compare at the command transfer and move only in the update step
  assign ctrl.cmp = accept;
  assign ctrl.op  = exec_go ? op_q : CELL_HOLD;

  ile_chain #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .tgt      (tgt_q),
    .ge       (ge_q),
    .new_word (word_q),
    .cmp_word (in_word),
    .match    (match),
    .rd_word  (rd_word)
  );

  // ---------------------------------------------------------------- select step
  logic [WW-1:0]       cnt_w;
  logic [WW-1:0]       pos_w;
  logic [WW-1:0]       p;
  logic                is_empty;
  logic                is_full;
  logic [DEPTH-1:0]    live;
  logic [DEPTH-1:0]    hit;
  logic [DEPTH-1:0]    ge_hit;
  logic [DEPTH-1:0]    first_hit;
  logic                use_hit;
  logic [1:0]          op_d;
  logic                rd_en_d;
  logic                found_d;
  logic [STATUS_W-1:0] status_d;
  logic [DEPTH-1:0]    tgt_d;
  logic [DEPTH-1:0]    ge_d;

  always_comb begin
    cnt_w    = WW'(count);
    pos_w    = WW'(pos_q);
    is_empty = (count == '0);
    is_full  = (cnt_w == WW'(DEPTH));

    // only entries below the count take part in a search
    for (int i = 0; i < DEPTH; i++) begin
      live[i] = (WW'(i) < cnt_w);
    end
    hit = match & live;

    // inclusive prefix or: set from the first hit onward
    ge_hit = hit;
    for (int k = 0; k < LVL; k++) begin
      ge_hit = ge_hit | (ge_hit << (1 << k));
    end
    first_hit = ge_hit & ~(ge_hit << 1);

    p        = '0;
    use_hit  = 1'b0;
    op_d     = CELL_HOLD;
    rd_en_d  = 1'b0;
    found_d  = 1'b0;
    status_d = STAT_OK;

    unique case (cmd_q) inside
      CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          op_d = CELL_OPEN;
          p    = (cmd_q == CMD_PUSH_HEAD) ? '0 : cnt_w;
        end
      end
      CMD_POP_HEAD, CMD_POP_TAIL: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          op_d    = CELL_CLOSE;
          rd_en_d = 1'b1;
          p       = (cmd_q == CMD_POP_HEAD) ? '0 : cnt_w - 1'b1;
        end
      end
      CMD_REPLACE: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_d = STAT_RANGE;
        end else begin
          op_d = CELL_WRITE;
          p    = pos_w;
        end
      end
      CMD_READ: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          rd_en_d = 1'b1;
          // read past the end clamps to the last entry
          p       = (pos_w >= cnt_w) ? cnt_w - 1'b1 : pos_w;
        end
      end
      CMD_INSERT: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else if (pos_w > cnt_w) begin
          status_d = STAT_RANGE;
        end else begin
          op_d = CELL_OPEN;
          p    = pos_w;
        end
      end
      CMD_DELETE: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status_d = STAT_RANGE;
        end else begin
          op_d    = CELL_CLOSE;
          rd_en_d = 1'b1;
          p       = pos_w;
        end
      end
      CMD_FIND, CMD_DEL_VALUE: begin
        use_hit = 1'b1;
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else if (hit == '0) begin
          status_d = STAT_NOT_FOUND;
        end else begin
          found_d = 1'b1;
          if (cmd_q == CMD_DEL_VALUE) begin
            op_d    = CELL_CLOSE;
            rd_en_d = 1'b1;
          end
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase

    for (int i = 0; i < DEPTH; i++) begin
      tgt_d[i] = use_hit ? first_hit[i] : (WW'(i) == p);
      ge_d[i]  = use_hit ? ge_hit[i]    : (WW'(i) >= p);
    end
  end

  // ---------------------------------------------------------------- update step
  logic [WW-1:0] fidx_w;
  logic [WW-1:0] cnt_next_w;

  always_comb begin
    fidx_w = '0;
    for (int i = 0; i < DEPTH; i++) begin
      fidx_w = fidx_w | (tgt_q[i] ? WW'(i) : '0);
    end
  end

  always_comb begin
    count_next = count;
    if (exec_go) begin
      case (op_q)
        CELL_OPEN:  count_next = count + 1'b1;
        CELL_CLOSE: count_next = count - 1'b1;
        default:    count_next = count;
      endcase
    end
    cnt_next_w = WW'(count_next);
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (exec_go) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command.cmd;
      pos_q  <= command.position;
      word_q <= in_word;
    end
    if (state == ST_SCAN) begin
      tgt_q    <= tgt_d;
      ge_q     <= ge_d;
      op_q     <= op_d;
      rd_en_q  <= rd_en_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
    if (exec_go) begin
      res_read_value  <= rd_en_q ? signed'(rd_ext) : '0;
      res_found_index <= found_q ? fidx_w[FIDX_W-1:0] : '0;
      res_found       <= found_q;
      res_entry_count <= cnt_next_w[CNT_OUT_W-1:0];
      res_status      <= status_q;
    end
  end

  assign result.valid       = res_valid;
  assign result.read_value  = res_read_value;
  assign result.found_index = res_found_index;
  assign result.found       = res_found;
  assign result.entry_count = res_entry_count;
  assign result.status      = res_status;

  // ---------------------------------------------------------------- checks
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    WW'(count) <= WW'(DEPTH))
    else $error("entry count exceeds depth");

  a_count_only_in_exec : assert property (@(posedge clk) disable iff (rst)
    !exec_go |=> $stable(count))
    else $error("entry count moved outside the update step");

  a_target_onehot : assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> $onehot0(tgt_q))
    else $error("more than one target cell");

  a_found_is_ok : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_found) |-> (res_status == STAT_OK))
    else $error("found flagged with an error status");

  a_transfer_to_scan : assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN))
    else $error("command transfer did not start the select step");

endmodule

// ----- hw/rtl/ile_cell.sv -----
// one list cell: holds a word, compares it, and shifts with its neighbors
// depends on ile_pkg
module ile_cell #(
  parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  ile_pkg::cell_ctrl_t    ctrl,
  input  logic                   tgt,
  input  logic                   ge,
  input  logic [DATA_WIDTH-1:0]  new_word,
  input  logic [DATA_WIDTH-1:0]  cmp_word,
  input  logic [DATA_WIDTH-1:0]  prev_word,
  input  logic [DATA_WIDTH-1:0]  next_word,
  output logic [DATA_WIDTH-1:0]  word,
  output logic                   match
);
  import ile_pkg::*;

  logic [DATA_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    unique case (ctrl.op)
      CELL_OPEN: begin
        if (tgt) begin
          word_next = new_word;
        end else if (ge) begin
          word_next = prev_word;
        end
      end
      CELL_CLOSE: begin
        if (ge) begin
          word_next = next_word;
        end
      end
      CELL_WRITE: begin
        if (tgt) begin
          word_next = new_word;
        end
      end
      default: begin
        word_next = word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
    if (ctrl.cmp) begin
      match <= (word == cmp_word);
    end
  end

endmodule

// ----- hw/rtl/ile_chain.sv -----
// row of list cells with neighbor links and the selected-word read path
// depends on ile_pkg and ile_cell
module ile_chain #(
  parameter int DEPTH      = ile_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  ile_pkg::cell_ctrl_t    ctrl,
  input  logic [DEPTH-1:0]       tgt,
  input  logic [DEPTH-1:0]       ge,
  input  logic [DATA_WIDTH-1:0]  new_word,
  input  logic [DATA_WIDTH-1:0]  cmp_word,
  output logic [DEPTH-1:0]       match,
  output logic [DATA_WIDTH-1:0]  rd_word
);
  import ile_pkg::*;

  logic [DATA_WIDTH-1:0] words     [DEPTH];
  logic [DATA_WIDTH-1:0] prev_link [DEPTH];
  logic [DATA_WIDTH-1:0] next_link [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_link[i] = new_word;
    end else begin : g_prev
      assign prev_link[i] = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_link[i] = '0;
    end else begin : g_next
      assign next_link[i] = words[i+1];
    end

    ile_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .tgt       (tgt[i]),
      .ge        (ge[i]),
      .new_word  (new_word),
      .cmp_word  (cmp_word),
      .prev_word (prev_link[i]),
      .next_word (next_link[i]),
      .word      (words[i]),
      .match     (match[i])
    );
  end

  // target is at most one-hot, so an and-or gathers its word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | (tgt[i] ? words[i] : '0);
    end
  end

endmodule
